### hw/rtl/amt_pkg.sv
// amt_pkg: shared widths, phase codes and item types for the motion trigger
// used by every module under hw/rtl; depends on nothing
`timescale 1ns / 1ps

package amt_pkg;

  localparam int SAMPLE_W    = 10;   // raw accelerometer sample
  localparam int SUM_W       = 14;   // per-axis window sum, holds 16 samples
  localparam int THR_W       = 9;    // trigger threshold register
  localparam int THR_RESET   = 26;   // about 0.2 g at 7.8 mg per lsb
  localparam int WINDOW_DEF  = 10;   // samples per window
  localparam int WINDOW_MAX  = 16;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 8;
  localparam int AXES        = 3;

  // result bit positions inside m_axis_tdata
  localparam int OUT_PHASE_LSB = 0;
  localparam int OUT_DONE_BIT  = 2;
  localparam int OUT_ALARM_BIT = 3;
  localparam int OUT_MASK_LSB  = 4;

  typedef enum logic [1:0] {
    PHASE_BASE  = 2'd0,
    PHASE_MON   = 2'd1,
    PHASE_ALARM = 2'd2
  } phase_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accel_z;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_x;
  } sample_t;

  typedef struct packed {
    logic [AXES-1:0] axis_mask;
    logic            alarm;
    logic            window_done;
    phase_t          phase;
  } result_t;

endpackage

### hw/rtl/accel_motion_trigger.sv
// accel_motion_trigger: top level of the baseline window motion trigger
// depends on amt_pkg, amt_in_reg and amt_axis_cmp
`timescale 1ns / 1ps

// usage
//   s_axis carries one three-axis sample per item; m_axis returns one result
//   item for every sample, in order. the first WINDOW samples are summed per
//   axis into a baseline; every later window of WINDOW samples is summed and
//   compared axis by axis. an axis fires on a strict sign flip of the sums or
//   when the magnitudes differ by more than trigger_threshold * WINDOW. any
//   firing axis latches the alarm; from then on samples are answered with
//   phase 2 and nothing else until reset.
//   cfg_we / cfg_wdata write trigger_threshold; the product with WINDOW is
//   kept in a register, so a write takes effect from the next cycle.
// path and throughput
//   a sample lands in the input register at the accepting edge, and the
//   result register loads once free or draining; one item per cycle while
//   m_axis does not stall, set by the single accumulate and compare pass.
// reset and stall
//   rst clears phase, count, sums and both valid flags, and loads threshold
//   26. a stalled m_axis holds its result; one more sample waits in the
//   input register, then s_axis_tready drops.
module accel_motion_trigger
  import amt_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // sample items
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // accel_x[9:0], accel_y[19:10], accel_z[29:20]
  // result items
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // phase[1:0], window_done[2], alarm[3], axis_mask[6:4]
  // threshold register
  input  logic                   cfg_we,
  input  logic [THR_W-1:0]       cfg_wdata
);

  localparam int CNT_W = $clog2(WINDOW + 1);   // holds WINDOW after increment
  localparam int LIM_W = THR_W + CNT_W;        // threshold * WINDOW

  // input register
  sample_t in_sample, held_sample;
  logic    held_valid, take;

  assign in_sample = sample_t'(s_axis_tdata[3*SAMPLE_W-1:0]);

  amt_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_sample   (in_sample),
    .held_valid  (held_valid),
    .held_sample (held_sample),
    .take        (take)
  );

  // state
  phase_t                   phase, phase_next;
  logic [CNT_W-1:0]         sample_count, count_inc;
  logic signed [SUM_W-1:0]  window_sum   [AXES];
  logic signed [SUM_W-1:0]  baseline_sum [AXES];
  logic signed [SUM_W-1:0]  sum_next     [AXES];
  logic [SAMPLE_W-1:0]      axis_sample  [AXES];
  logic [LIM_W-1:0]         limit;
  logic [AXES-1:0]          trig;
  logic                     done;

  // result register
  logic    out_valid;
  result_t out_result, result_next;

  // a held sample moves on whenever the result register is free or draining
  assign take = held_valid && (!out_valid || m_axis_tready);

  // threshold kept pre-scaled by the window length
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIM_W'(LIM_W'(THR_RESET) * LIM_W'(WINDOW));
    end else if (cfg_we) begin
      limit <= LIM_W'(LIM_W'(cfg_wdata) * LIM_W'(WINDOW));
    end
  end

  assign axis_sample[0] = held_sample.accel_x;
  assign axis_sample[1] = held_sample.accel_y;
  assign axis_sample[2] = held_sample.accel_z;

  // accumulate this sample and test each axis against the baseline
  for (genvar a = 0; a < AXES; a++) begin : g_axis
    assign sum_next[a] = window_sum[a]
                       + {{(SUM_W-SAMPLE_W){axis_sample[a][SAMPLE_W-1]}}, axis_sample[a]};

    amt_axis_cmp #(
      .LIM_W (LIM_W)
    ) u_cmp (
      .base_sum (baseline_sum[a]),
      .cur_sum  (sum_next[a]),
      .limit    (limit),
      .trig     (trig[a])
    );
  end

  assign count_inc = sample_count + CNT_W'(1);
  assign done      = (count_inc == CNT_W'(WINDOW));

  // phase next state
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PHASE_BASE: begin
        if (done) begin
          phase_next = PHASE_MON;
        end
      end
      PHASE_MON: begin
        if (done && (trig != '0)) begin
          phase_next = PHASE_ALARM;
        end
      end
      PHASE_ALARM: begin
        phase_next = PHASE_ALARM;
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  // result fields for the held sample
  always_comb begin
    result_next             = '0;
    result_next.phase       = phase_next;
    unique case (phase)
      PHASE_BASE: begin
        result_next.window_done = done;
      end
      PHASE_MON: begin
        result_next.window_done = done;
        result_next.alarm       = done && (trig != '0);
        result_next.axis_mask   = done ? trig : '0;
      end
      PHASE_ALARM: begin
        // latched: samples are ignored
        result_next.window_done = 1'b0;
      end
      default: begin
        result_next.window_done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PHASE_BASE;
      sample_count <= '0;
    end else if (take && (phase != PHASE_ALARM)) begin
      phase        <= phase_next;
      sample_count <= done ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        window_sum[a]   <= '0;
        baseline_sum[a] <= '0;
      end
    end else if (take && (phase != PHASE_ALARM)) begin
      for (int a = 0; a < AXES; a++) begin
        window_sum[a] <= done ? '0 : sum_next[a];
        if (done && (phase == PHASE_BASE)) begin
          baseline_sum[a] <= sum_next[a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_result <= result_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_result};

endmodule

### hw/rtl/amt_in_reg.sv
// amt_in_reg: input register of the motion trigger, one sample deep
// depends on amt_pkg for the sample type
`timescale 1ns / 1ps

module amt_in_reg
  import amt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t in_sample,
  output logic    held_valid,
  output sample_t held_sample,
  input  logic    take
);

  logic held_valid_next;

  // refill in the same cycle the held sample moves on
  assign in_ready = !held_valid || take;

  always_comb begin
    held_valid_next = held_valid;
    if (in_valid && in_ready) begin
      held_valid_next = 1'b1;
    end else if (take) begin
      held_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_sample <= in_sample;
    end
  end

endmodule

### hw/rtl/amt_axis_cmp.sv
// amt_axis_cmp: trigger test of one axis, window sum against baseline sum
// depends on amt_pkg for the sum width
`timescale 1ns / 1ps

module amt_axis_cmp
  import amt_pkg::*;
#(
  parameter int LIM_W = 13
) (
  input  logic signed [SUM_W-1:0] base_sum,
  input  logic signed [SUM_W-1:0] cur_sum,
  input  logic        [LIM_W-1:0] limit,
  output logic                    trig
);

  localparam int CMP_W = (SUM_W + 1 > LIM_W) ? SUM_W + 1 : LIM_W;

  logic              base_neg, base_pos, cur_neg, cur_pos;
  logic [SUM_W-1:0]  base_abs, cur_abs;
  logic [SUM_W:0]    diff, diff_abs;
  logic              flip;

  assign base_neg = base_sum[SUM_W-1];
  assign cur_neg  = cur_sum[SUM_W-1];
  assign base_pos = !base_neg && (base_sum != '0);
  assign cur_pos  = !cur_neg && (cur_sum != '0);

  // zero counts as neither sign
  assign flip = (base_neg && cur_pos) || (base_pos && cur_neg);

  // magnitudes as unsigned, so the most negative sum still fits
  assign base_abs = base_neg ? SUM_W'(-base_sum) : SUM_W'(base_sum);
  assign cur_abs  = cur_neg  ? SUM_W'(-cur_sum)  : SUM_W'(cur_sum);

  assign diff     = {1'b0, base_abs} - {1'b0, cur_abs};
  assign diff_abs = diff[SUM_W] ? (SUM_W+1)'(-diff) : diff;

  assign trig = flip || (CMP_W'(diff_abs) > CMP_W'(limit));

endmodule

### hw/rtl/amt_checker.sv
// amt_checker: port-level assertions for accel_motion_trigger, with its bind
// depends on amt_pkg for the result layout and phase codes
`timescale 1ns / 1ps

module amt_checker
  import amt_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [1:0]      phase;
  logic            done, alarm;
  logic [AXES-1:0] mask;

  assign phase = m_axis_tdata[OUT_PHASE_LSB +: 2];
  assign done  = m_axis_tdata[OUT_DONE_BIT];
  assign alarm = m_axis_tdata[OUT_ALARM_BIT];
  assign mask  = m_axis_tdata[OUT_MASK_LSB +: AXES];

  // an alarm comes only from a finished window with a firing axis
  a_alarm_cause: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && alarm |-> done && (mask != '0) && (phase == PHASE_ALARM))
    else $error("alarm without a finished window and firing axis");

  // a firing axis always raises the alarm
  a_mask_alarm: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (mask != '0) |-> alarm)
    else $error("axis mask set without alarm");

  // while still collecting the baseline nothing can fire
  a_base_quiet: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (phase == PHASE_BASE) |-> !alarm && (mask == '0))
    else $error("trigger during baseline collection");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind accel_motion_trigger amt_checker u_amt_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### test/amt_result_check.sv
`timescale 1ns / 1ps
// amt_result_check: watches the sample, result and threshold ports of the motion trigger,
// works out each result from its own copy of the window state and compares field by field
// depends on amt_pkg only
module amt_result_check
  import amt_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we,
  input  logic [THR_W-1:0]       cfg_wdata,
  output int                     pending,
  output int                     fails
);

  phase_t                  phase_q;
  logic [4:0]              taken;
  logic signed [SUM_W-1:0] run_sum  [AXES];
  logic signed [SUM_W-1:0] base_sum [AXES];
  logic [THR_W-1:0]        thr_q;
  result_t                 verdicts_due [$];
  result_t                 want;
  result_t                 got;

  // strict sign flip, or magnitudes apart by more than the limit
  function automatic bit axis_moved(int b, int c, int lim);
    int d;
    if ((b < 0 && c > 0) || (b > 0 && c < 0)) return 1'b1;
    d = (b < 0 ? -b : b) - (c < 0 ? -c : c);
    return (d < 0 ? -d : d) > lim;
  endfunction

  function automatic result_t motion_verdict(sample_t s);
    result_t                    r;
    logic signed [SAMPLE_W-1:0] lane [AXES];
    int                         lim;
    r = '0;
    if (phase_q == PHASE_ALARM) begin
      // latched: sample dropped, state untouched
      r.phase = PHASE_ALARM;
      return r;
    end
    lane[0] = s.accel_x;
    lane[1] = s.accel_y;
    lane[2] = s.accel_z;
    for (int a = 0; a < AXES; a++) run_sum[a] += lane[a];
    taken += 5'd1;
    if (taken >= WINDOW) begin
      r.window_done = 1'b1;
      if (phase_q == PHASE_BASE) begin
        base_sum = run_sum;
        phase_q  = PHASE_MON;
      end else begin
        lim = int'(thr_q) * WINDOW;
        for (int a = 0; a < AXES; a++) r.axis_mask[a] = axis_moved(base_sum[a], run_sum[a], lim);
        if (r.axis_mask != '0) begin
          r.alarm = 1'b1;
          phase_q = PHASE_ALARM;
        end
      end
      taken = '0;
      for (int a = 0; a < AXES; a++) run_sum[a] = '0;
    end
    r.phase = phase_q;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      phase_q = PHASE_BASE;
      taken   = '0;
      thr_q   = THR_W'(THR_RESET);
      for (int a = 0; a < AXES; a++) begin
        run_sum[a]  = '0;
        base_sum[a] = '0;
      end
      verdicts_due.delete();
    end else begin
      // results first, so a result can never be matched to a sample of the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(result_t)-1:0];
        if (verdicts_due.size() == 0) begin
          $error("result item with no expectation waiting: %h", m_axis_tdata);
          fails += 1;
        end else begin
          want = verdicts_due.pop_front();
          if (got.phase != want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, got.phase);
            fails += 1;
          end
          if (got.window_done != want.window_done) begin
            $error("window_done: expected %0d, got %0d", want.window_done, got.window_done);
            fails += 1;
          end
          if (got.alarm != want.alarm) begin
            $error("alarm: expected %0d, got %0d", want.alarm, got.alarm);
            fails += 1;
          end
          if (got.axis_mask != want.axis_mask) begin
            $error("axis_mask: expected %0d, got %0d", want.axis_mask, got.axis_mask);
            fails += 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        verdicts_due.push_back(motion_verdict(s_axis_tdata[$bits(sample_t)-1:0]));
      // threshold applies from the next cycle on
      if (cfg_we) thr_q = cfg_wdata;
    end
    pending <= verdicts_due.size();
  end

endmodule

### test/tb_accel_motion_trigger.sv
`timescale 1ns / 1ps
// tb_accel_motion_trigger: sample and threshold stimulus for the motion trigger, plus verdict
// depends on amt_pkg, accel_motion_trigger and amt_result_check
module tb_accel_motion_trigger;
  import amt_pkg::*;

  localparam int WINDOW      = WINDOW_DEF;
  localparam int SMIN        = -(1 << (SAMPLE_W - 1));
  localparam int SMAX        = (1 << (SAMPLE_W - 1)) - 1;
  localparam int SUM_MIN     = WINDOW * SMIN;
  localparam int SUM_MAX     = WINDOW * SMAX;
  localparam int THR_MAX     = (1 << THR_W) - 1;
  localparam int PHASES      = 8;
  localparam int WINS        = 15;     // windows per phase
  localparam int TAIL        = 20;     // samples sent after the alarm latched
  localparam int QUIET_LIMIT = 2000;

  logic                   clk;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we        = 1'b0;
  logic [THR_W-1:0]       cfg_wdata     = '0;

  int src_pct  = 0;    // chance in percent that the sender idles a cycle
  int sink_pct = 0;    // chance in percent that the receiver stalls a cycle
  int pending;
  int fails;
  int quiet    = 0;
  int base_sum [AXES]; // baseline sums as sent, used to shape later windows
  int thr_now  = THR_RESET;

  accel_motion_trigger #(.WINDOW(WINDOW)) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  amt_result_check #(.WINDOW(WINDOW)) u_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .pending       (pending),
    .fails         (fails)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_pct);
  end

  // ends the run when nothing moves on either side for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic sample_t make_sample(int x, int y, int z);
    sample_t s;
    s.accel_x = SAMPLE_W'(x);
    s.accel_y = SAMPLE_W'(y);
    s.accel_z = SAMPLE_W'(z);
    return s;
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // uniform, with the two ends favored
  function automatic int pick_in(int lo, int hi);
    case ($urandom_range(3))
      0:       return lo;
      1:       return hi;
      default: return lo + int'($urandom_range(hi - lo));
    endcase
  endfunction

  // window sum that keeps the axis quiet: same side of zero, magnitude within the limit
  function automatic int calm_target(int b, int lim);
    int lo, hi;
    lo = (b > 0) ? 0 : SUM_MIN;
    hi = (b < 0) ? 0 : SUM_MAX;
    if (b - lim > lo) lo = b - lim;
    if (b + lim < hi) hi = b + lim;
    return pick_in(lo, hi);
  endfunction

  // window sum that fires the axis: magnitude too high, too low, or a sign flip
  function automatic int jolt_target(int b, int lim);
    int m;
    m = (b < 0) ? -b : b;
    case ($urandom_range(2))
      0: begin
        if (b >= 0 && m + lim + 1 <= SUM_MAX) return pick_in(m + lim + 1, SUM_MAX);
        if (b <= 0 && -(m + lim + 1) >= SUM_MIN) return pick_in(SUM_MIN, -(m + lim + 1));
      end
      1: begin
        if (m - lim - 1 >= 0) return (b > 0) ? pick_in(0, m - lim - 1) : pick_in(-(m - lim - 1), 0);
      end
      default: ;
    endcase
    if (b > 0) return pick_in(SUM_MIN, -1);
    if (b < 0) return pick_in(1, SUM_MAX);
    return pick_in(SUM_MIN, -(lim + 1));
  endfunction

  task automatic push_item(input sample_t s);
    while ($urandom_range(99) < src_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(s);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // one full window whose per-axis sums hit the targets exactly, with random spread
  task automatic send_window(input int tgt [AXES]);
    int v [AXES][WINDOW];
    int rem, left, lo, hi;
    for (int a = 0; a < AXES; a++) begin
      rem = tgt[a];
      for (int i = 0; i < WINDOW; i++) begin
        left = WINDOW - 1 - i;
        // keep what is left reachable by the remaining samples
        lo = (rem - left * SMAX > SMIN) ? rem - left * SMAX : SMIN;
        hi = (rem - left * SMIN < SMAX) ? rem - left * SMIN : SMAX;
        case ($urandom_range(7))
          0, 1, 2, 3: v[a][i] = clamp(rem / (left + 1) + int'($urandom_range(128)) - 64, lo, hi);
          4:          v[a][i] = lo;
          5:          v[a][i] = hi;
          default:    v[a][i] = lo + int'($urandom_range(hi - lo));
        endcase
        rem -= v[a][i];
      end
    end
    for (int i = 0; i < WINDOW; i++) push_item(make_sample(v[0][i], v[1][i], v[2][i]));
  endtask

  // wait until every sample sent has its result back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int      still_pat [AXES][10];
    int      tgt [AXES];
    int      mask;
    bit      fire;
    sample_t s;

    // baseline pattern: full-scale swings on x and y, z summing to exactly zero
    still_pat = '{'{511, -512, 511, 511, -512, 0, 300, 300, 300, 300},
                  '{-512, 511, -512, -512, 511, 0, -300, -300, -300, -300},
                  '{0, 0, 511, -512, 1, 0, 0, 0, 0, 0}};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // baseline window at the reset threshold
    for (int a = 0; a < AXES; a++) base_sum[a] = 0;
    for (int i = 0; i < WINDOW; i++) begin
      for (int a = 0; a < AXES; a++) base_sum[a] += still_pat[a][i % 10];
      push_item(make_sample(still_pat[0][i % 10], still_pat[1][i % 10], still_pat[2][i % 10]));
    end

    // every axis exactly at the limit, which must not fire; z moves off a zero baseline
    tgt[0] = base_sum[0] + THR_RESET * WINDOW;
    tgt[1] = base_sum[1] - THR_RESET * WINDOW;
    tgt[2] = base_sum[2] + THR_RESET * WINDOW;
    send_window(tgt);

    // random windows under several thresholds and idling patterns, alarm only at the very end
    mask = $urandom_range(1, 7);
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0, 5:    thr_now = THR_MAX;
        1, 4:    thr_now = 0;
        2:       thr_now = $urandom_range(1, 60);
        default: thr_now = $urandom_range(THR_MAX);
      endcase
      cfg_we    <= 1'b1;
      cfg_wdata <= THR_W'(thr_now);
      @(posedge clk);
      cfg_we    <= 1'b0;
      case (p % 4)
        0: begin src_pct = 0;  sink_pct = 0;  end
        1: begin src_pct = 74; sink_pct = 0;  end
        2: begin src_pct = 0;  sink_pct = 74; end
        default: begin src_pct = 13; sink_pct = 13; end
      endcase
      for (int w = 0; w < WINS; w++) begin
        for (int a = 0; a < AXES; a++) begin
          fire   = (p == PHASES - 1) && (w == WINS - 1) && mask[a];
          tgt[a] = fire ? jolt_target(base_sum[a], thr_now * WINDOW)
                        : calm_target(base_sum[a], thr_now * WINDOW);
        end
        send_window(tgt);
      end
    end

    // alarm latched: everything after this is dropped
    for (int i = 0; i < TAIL; i++) begin
      s = $bits(sample_t)'($urandom);
      push_item(s);
    end

    drain();
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### accel_motion_trigger.f
hw/rtl/amt_pkg.sv
hw/rtl/amt_in_reg.sv
hw/rtl/amt_axis_cmp.sv
hw/rtl/accel_motion_trigger.sv
hw/rtl/amt_checker.sv
test/amt_result_check.sv
test/tb_accel_motion_trigger.sv
